/* hw/rtl/hts_pkg.sv */
package hts_pkg;

	localparam int TIMER_SLOTS_DEF = 64;
	localparam int MAX_RESULTS = 64;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_STOP   = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] RES_START  = 2'd0;
	localparam logic [1:0] RES_STOP   = 2'd1;
	localparam logic [1:0] RES_EXPIRY = 2'd2;
	localparam logic [1:0] RES_EMPTY  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BUSY      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// one heap entry as kept in the slot memory
	typedef struct packed {
		logic [63:0] expiry;
		logic [31:0] id;
		logic [31:0] interval;
		logic        periodic;
		logic [31:0] dest;
		logic [31:0] code;
	} slot_t;

	// s_tuser: kind[1:0]
	// s_tdata: delay[31:0] periodic[32] dest[64:33] code[96:65] stop_id[128:97],
	// padded to 136 bits
	localparam int IN_W = 136;
	// m_tuser: result_kind[1:0]
	// m_tdata: status[1:0] id[33:2] dest[65:34] code[97:66], padded to 104 bits
	localparam int OUT_W = 104;

endpackage

/* hw/rtl/heap_timer_scheduler.sv */
// Timer queue on a binary min-heap of absolute expiry ticks, held in one slot
// memory with a registered read. Each transfer on s_* is a start,
// stop or tick, selected by s_tuser; results leave on m_* with m_tuser giving
// the result kind and m_tlast marking the last result of an item. Items are
// handled one at a time: s_tready is high only while idle. Every memory read
// takes an address state, then a data state. A start is accepted, climbs the
// heap one level per read and compare, settles, then waits in the output
// register. A stop searches slot by slot from the root (up to TIMER_SLOTS
// slots), then fetches the last entry, sifts it up or down, and goes to the
// output register. A tick reads the root; each expired entry then fetches the
// last entry, sifts it down, decides on a reload, sifts a periodic reload up,
// and re-reads the root before its result is offered and again after it is
// taken. Each result waits in the output register until taken, which adds
// every stall on m_tready. No clearing pass is needed after reset: only data
// from slots below the entry count is ever used.
module heap_timer_scheduler #(
	parameter int TIMER_SLOTS = hts_pkg::TIMER_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [hts_pkg::IN_W-1:0]  s_tdata,  // delay, periodic, dest, code,
	                                            // stop_id
	input  logic [1:0]                s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [hts_pkg::OUT_W-1:0] m_tdata,  // status, id, dest, code
	output logic [1:0]                m_tuser,  // result kind
	output logic                      m_tlast
);
	import hts_pkg::*;

	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int RW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_UP_RD   = 14'b00000000000010, // read parent of pos
		S_UP_CMP  = 14'b00000000000100, // compare cur with parent
		S_DN_CHK  = 14'b00000000001000, // read left child, or settle
		S_DN_RDR  = 14'b00000000010000, // left data back, read right
		S_DN_CMP  = 14'b00000000100000, // right data back, decide
		S_SR_RD   = 14'b00000001000000, // search: read slot pos
		S_SR_CMP  = 14'b00000010000000,
		S_LST_RD  = 14'b00000100000000, // read last entry to fill the hole
		S_LST_GET = 14'b00001000000000,
		S_TK_RD   = 14'b00010000000000, // read root
		S_TK_CHK  = 14'b00100000000000,
		S_TK_INS  = 14'b01000000000000, // reload a periodic entry
		S_OUT     = 14'b10000000000000  // hold a result until taken
	} state_t;

	state_t        state_q, after_out_q, ret_q;
	logic [63:0]   now_q;
	logic [CW-1:0] count_q;
	logic [31:0]   next_id_q;

	// item being worked on
	logic [1:0]    kind_q;
	logic [31:0]   stop_id_q;
	slot_t         cur_q;        // entry being sifted, lives in the hole at pos_q
	logic [AW-1:0] pos_q;
	logic          down_after_q; // stop: sift down if sift up did not move
	slot_t         left_q;
	slot_t         popped_q;
	logic          pend_q;       // popped entry not yet reported
	logic [RW-1:0] n_q;

	// memory
	slot_t         mem [TIMER_SLOTS];
	slot_t         rd_q;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// output register
	logic [1:0]  o_kind_q, o_status_q;
	logic [31:0] o_id_q, o_dest_q, o_code_q;
	logic        o_last_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_kind_q;
	assign m_tdata  = {6'd0, o_code_q, o_dest_q, o_id_q, o_status_q};

	// heap navigation around pos_q
	logic [AW:0]   lchild, rchild;
	logic [AW-1:0] parent;
	logic          has_left, has_right, take_right;
	slot_t         pick;
	logic [AW-1:0] pick_idx;
	logic          up_move, dn_move, expired;

	assign lchild     = {pos_q, 1'b1};
	assign rchild     = {pos_q, 1'b0} + (AW+1)'(2);
	assign parent     = (pos_q - AW'(1)) >> 1;
	assign has_left   = lchild < (AW+1)'(count_q);
	assign has_right  = rchild < (AW+1)'(count_q);
	assign take_right = has_right && (rd_q.expiry < left_q.expiry);
	assign pick       = take_right ? rd_q : left_q;
	assign pick_idx   = take_right ? rchild[AW-1:0] : lchild[AW-1:0];
	assign up_move    = cur_q.expiry < rd_q.expiry;
	assign dn_move    = cur_q.expiry > pick.expiry;
	// root expired before this tick advanced the clock
	assign expired    = (count_q != '0) && (n_q != RW'(MAX_RESULTS)) &&
	                    (rd_q.expiry <= now_q - 64'd1);

	// memory control: move a parent or child into the hole, or settle cur_q
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			S_UP_RD: begin
				rd_addr = parent;
				if (pos_q == '0 && !down_after_q)
					we = 1'b1;
			end
			S_UP_CMP: begin
				if (up_move) begin
					we      = 1'b1;
					wr_data = rd_q;
				end else if (!down_after_q) begin
					we = 1'b1;
				end
			end
			S_DN_CHK: begin
				rd_addr = lchild[AW-1:0];
				if (!has_left)
					we = 1'b1;
			end
			S_DN_RDR: rd_addr = rchild[AW-1:0];
			S_DN_CMP: begin
				we = 1'b1;
				if (dn_move)
					wr_data = pick;
			end
			S_SR_RD:  rd_addr = pos_q;
			S_LST_RD: rd_addr = AW'(count_q);
			default: ;
		endcase
	end

	task automatic put_out(input logic [1:0] k, input logic [1:0] s,
	                       input logic [31:0] id, input logic [31:0] d,
	                       input logic [31:0] c, input logic l);
		o_kind_q   <= k;
		o_status_q <= s;
		o_id_q     <= id;
		o_dest_q   <= d;
		o_code_q   <= c;
		o_last_q   <= l;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			after_out_q  <= S_IDLE;
			ret_q        <= S_IDLE;
			now_q        <= '0;
			count_q      <= '0;
			next_id_q    <= 32'd1;
			kind_q       <= KIND_START;
			down_after_q <= 1'b0;
			pend_q       <= 1'b0;
			n_q          <= '0;
			o_last_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q    <= s_tuser;
						stop_id_q <= s_tdata[128:97];
						n_q       <= '0;
						pend_q    <= 1'b0;
						case (s_tuser)
							KIND_START: begin
								if (count_q >= CW'(TIMER_SLOTS)) begin
									put_out(RES_START, ST_BUSY, '0, '0, '0, 1'b1);
									after_out_q <= S_IDLE;
									state_q     <= S_OUT;
								end else begin
									cur_q <= '{expiry: now_q + {32'd0, s_tdata[31:0]},
									           id: next_id_q, interval: s_tdata[31:0],
									           periodic: s_tdata[32], dest: s_tdata[64:33],
									           code: s_tdata[96:65]};
									// id zero is never handed out
									next_id_q    <= (next_id_q == 32'hFFFF_FFFF) ?
									                32'd1 : next_id_q + 32'd1;
									put_out(RES_START, ST_OK, next_id_q, '0, '0, 1'b1);
									pos_q        <= AW'(count_q);
									count_q      <= count_q + CW'(1);
									down_after_q <= 1'b0;
									ret_q        <= S_OUT;
									after_out_q  <= S_IDLE;
									state_q      <= S_UP_RD;
								end
							end
							KIND_STOP: begin
								pos_q <= '0;
								if (count_q == '0) begin
									put_out(RES_STOP, ST_NOT_FOUND, s_tdata[128:97], '0, '0,
									        1'b1);
									after_out_q <= S_IDLE;
									state_q     <= S_OUT;
								end else begin
									state_q <= S_SR_RD;
								end
							end
							KIND_TICK: begin
								now_q   <= now_q + 64'd1;
								state_q <= S_TK_RD;
							end
							default: ; // unknown kind: drop the transfer
						endcase
					end
				end
				// sift up: the hole climbs while cur_q is earlier than the parent
				S_UP_RD: begin
					if (pos_q == '0) begin
						if (down_after_q) begin
							down_after_q <= 1'b0;
							state_q      <= S_DN_CHK;
						end else begin
							state_q <= ret_q;
						end
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_move) begin
						pos_q        <= parent;
						down_after_q <= 1'b0;
						state_q      <= S_UP_RD;
					end else if (down_after_q) begin
						down_after_q <= 1'b0;
						state_q      <= S_DN_CHK;
					end else begin
						state_q <= ret_q;
					end
				end
				// sift down: the hole sinks while cur_q is later than the earlier child
				S_DN_CHK: state_q <= has_left ? S_DN_RDR : ret_q;
				S_DN_RDR: begin
					left_q  <= rd_q;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (dn_move) begin
						pos_q   <= pick_idx;
						state_q <= S_DN_CHK;
					end else begin
						state_q <= ret_q;
					end
				end
				// stop: linear search from the root, lowest index wins
				S_SR_RD: state_q <= S_SR_CMP;
				S_SR_CMP: begin
					if (rd_q.id == stop_id_q) begin
						put_out(RES_STOP, ST_OK, stop_id_q, '0, '0, 1'b1);
						count_q     <= count_q - CW'(1);
						after_out_q <= S_IDLE;
						if (CW'(pos_q) == count_q - CW'(1)) begin
							state_q <= S_OUT;
						end else begin
							down_after_q <= 1'b1;
							ret_q        <= S_OUT;
							state_q      <= S_LST_RD;
						end
					end else if (CW'(pos_q) == count_q - CW'(1)) begin
						put_out(RES_STOP, ST_NOT_FOUND, stop_id_q, '0, '0, 1'b1);
						after_out_q <= S_IDLE;
						state_q     <= S_OUT;
					end else begin
						pos_q   <= pos_q + AW'(1);
						state_q <= S_SR_RD;
					end
				end
				// fetch the last entry into cur_q to fill the hole
				S_LST_RD: state_q <= S_LST_GET;
				S_LST_GET: begin
					cur_q <= rd_q;
					if (kind_q == KIND_TICK) begin
						pos_q   <= '0;
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_UP_RD;
					end
				end
				// tick: report a pending pop once the next root is known, then pop
				S_TK_RD: state_q <= S_TK_CHK;
				S_TK_CHK: begin
					if (pend_q) begin
						put_out(RES_EXPIRY, ST_OK, popped_q.id, popped_q.dest,
						        popped_q.code, !expired);
						pend_q      <= 1'b0;
						after_out_q <= expired ? S_TK_RD : S_IDLE;
						state_q     <= S_OUT;
					end else if (expired) begin
						popped_q     <= rd_q;
						pend_q       <= 1'b1;
						n_q          <= n_q + RW'(1);
						count_q      <= count_q - CW'(1);
						down_after_q <= 1'b0;
						ret_q        <= S_TK_INS;
						state_q      <= (count_q == CW'(1)) ? S_TK_INS : S_LST_RD;
					end else begin
						put_out(RES_EMPTY, ST_OK, '0, '0, '0, 1'b1);
						after_out_q <= S_IDLE;
						state_q     <= S_OUT;
					end
				end
				S_TK_INS: begin
					if (popped_q.periodic) begin
						cur_q <= '{expiry: now_q + {32'd0, popped_q.interval},
						           id: popped_q.id, interval: popped_q.interval,
						           periodic: popped_q.periodic, dest: popped_q.dest,
						           code: popped_q.code};
						pos_q        <= AW'(count_q);
						count_q      <= count_q + CW'(1);
						down_after_q <= 1'b0;
						ret_q        <= S_TK_RD;
						state_q      <= S_UP_RD;
					end else begin
						state_q <= S_TK_RD;
					end
				end
				S_OUT: begin
					if (m_tready)
						state_q <= after_out_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/hts_checker.sv */
module hts_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [hts_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                m_tuser,
	input logic                      m_tlast
);
	import hts_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result changed while stalled");

	// one item at a time: no input taken while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("input ready while result pending");

	// acks and empty ticks are always the last result
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_START || m_tuser == RES_STOP ||
		m_tuser == RES_EMPTY) |-> m_tlast)
		else $error("ack without last");

	// expiries carry ok status
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RES_EXPIRY |-> m_tdata[1:0] == ST_OK)
		else $error("expiry with bad status");
endmodule

bind heap_timer_scheduler hts_checker u_hts_checker (.*);

/* tb/heap_timer_scheduler_tb.sv */
module heap_timer_scheduler_tb;
	import hts_pkg::*;

	localparam int SLOTS = TIMER_SLOTS_DEF;

	typedef struct packed {
		logic [1:0]  rkind;
		logic [1:0]  status;
		logic [31:0] id;
		logic [31:0] dest;
		logic [31:0] code;
		logic        last;
	} timer_event_t;

	// Shadow timer heap: predicts the results of each accepted transfer and
	// checks the results leaving the block against them in order.
	class timer_scoreboard;
		logic [63:0] now;
		int          count;
		logic [31:0] next_id;
		slot_t       heap[SLOTS];
		timer_event_t pending[$];
		int          errors;
		int          seen;
		int          expiries;

		function void clear();
			now = 64'd0;
			count = 0;
			next_id = 32'd1;
			pending.delete();
			errors = 0;
			seen = 0;
			expiries = 0;
		endfunction

		function void swap_slots(int a, int b);
			slot_t t;
			t = heap[a];
			heap[a] = heap[b];
			heap[b] = t;
		endfunction

		function void raise(int pos);
			int up;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (heap[pos].expiry >= heap[up].expiry)
					break;
				swap_slots(pos, up);
				pos = up;
			end
		endfunction

		function void lower(int pos);
			int pick;
			while (pos * 2 + 1 < count) begin
				pick = pos * 2 + 1;
				if (pick + 1 < count && heap[pick + 1].expiry < heap[pick].expiry)
					pick = pick + 1;
				if (heap[pos].expiry <= heap[pick].expiry)
					break;
				swap_slots(pos, pick);
				pos = pick;
			end
		endfunction

		function void add_timer(slot_t s);
			if (count >= SLOTS)
				return;
			heap[count] = s;
			count++;
			raise(count - 1);
		endfunction

		function void note(logic [1:0] kind, logic [31:0] ival, logic per,
			logic [31:0] dst, logic [31:0] cd, logic [31:0] sid);
			timer_event_t ev;
			slot_t s;
			logic [63:0] prior;
			int n;
			bit hit;
			ev = '0;
			ev.last = 1'b1;
			case (kind)
			KIND_START: begin
				ev.rkind = RES_START;
				if (count >= SLOTS) begin
					ev.status = ST_BUSY;
				end else begin
					ev.id = next_id;
					next_id = next_id + 32'd1;
					if (next_id == 32'd0)
						next_id = 32'd1;
					s.expiry = now + {32'd0, ival};
					s.id = ev.id;
					s.interval = ival;
					s.periodic = per;
					s.dest = dst;
					s.code = cd;
					add_timer(s);
				end
				pending.push_back(ev);
			end
			KIND_STOP: begin
				ev.rkind = RES_STOP;
				ev.id = sid;
				hit = 0;
				for (int i = 0; i < count && !hit; i++) begin
					if (heap[i].id == sid) begin
						hit = 1;
						count--;
						if (i != count) begin
							heap[i] = heap[count];
							raise(i);
							lower(i);
						end
					end
				end
				ev.status = hit ? ST_OK : ST_NOT_FOUND;
				pending.push_back(ev);
			end
			KIND_TICK: begin
				prior = now;
				now = now + 64'd1;
				n = 0;
				while (n < MAX_RESULTS && count > 0 && heap[0].expiry <= prior) begin
					s = heap[0];
					count--;
					if (count > 0) begin
						heap[0] = heap[count];
						lower(0);
					end
					if (s.periodic) begin
						s.expiry = now + {32'd0, s.interval};
						add_timer(s);
					end
					ev = '0;
					ev.rkind = RES_EXPIRY;
					ev.id = s.id;
					ev.dest = s.dest;
					ev.code = s.code;
					pending.push_back(ev);
					n++;
				end
				if (n == 0) begin
					ev = '0;
					ev.rkind = RES_EMPTY;
					ev.last = 1'b1;
					pending.push_back(ev);
				end else begin
					pending[pending.size() - 1].last = 1'b1;
				end
			end
			default: ;
			endcase
		endfunction

		function void check(logic [OUT_W-1:0] data, logic [1:0] user, logic last);
			timer_event_t want;
			timer_event_t got;
			got.rkind = user;
			got.status = data[1:0];
			got.id = data[33:2];
			got.dest = data[65:34];
			got.code = data[97:66];
			got.last = last;
			seen++;
			if (got.rkind == RES_EXPIRY)
				expiries++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected kind %0d st %0d id %h dest %h code %h last %b",
					$time, want.rkind, want.status, want.id, want.dest, want.code, want.last);
				$display("%0t:          actual   kind %0d st %0d id %h dest %h code %h last %b",
					$time, got.rkind, got.status, got.id, got.dest, got.code, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	timer_scoreboard board;
	bit               calm;     // no idling in the final stretch
	int               sent;

	heap_timer_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold the run to a fixed ceiling, well above the slowest legal run.
	initial begin
		#50_000_000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: stall in random bursts unless in the calm stretch.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
				@(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check(m_tdata, m_tuser, m_tlast);
	end

	// Present one item, after a random idle gap unless calm, and hold it until
	// the transfer; valid is dropped only by such a gap or by go_idle.
	task automatic send_item(logic [1:0] kind, logic [31:0] ival, logic per,
		logic [31:0] dst, logic [31:0] cd, logic [31:0] sid);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, sid, cd, dst, per, ival};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note(kind, ival, per, dst, cd, sid);
		sent++;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_timer(logic [31:0] ival, logic per);
		send_item(KIND_START, ival, per, $urandom, $urandom, $urandom);
	endtask

	task automatic stop_timer(logic [31:0] sid);
		send_item(KIND_STOP, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom, sid);
	endtask

	task automatic tick();
		send_item(KIND_TICK, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
			$urandom);
	endtask

	// Pick an id that is probably live, sometimes a stale or absent one.
	function automatic logic [31:0] pick_id();
		if (board.count > 0 && $urandom_range(0, 3) != 0)
			return board.heap[$urandom_range(0, board.count - 1)].id;
		return $urandom_range(0, board.next_id + 2);
	endfunction

	initial begin
		int limit;
		board = new();
		board.clear();
		calm = 0;
		sent = 0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_START;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, stop of id 0 and of an absent id, field extremes,
		// zero interval periodic, ties, the unknown kind.
		tick();
		stop_timer(32'd0);
		stop_timer(32'hFFFF_FFFF);
		send_item(KIND_START, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_START, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0);
		send_item(KIND_START, 32'd1, 1'b0, 32'hAAAA_5555, 32'h5555_AAAA, 32'd0);
		send_item(KIND_START, 32'd1, 1'b1, 32'h1234_5678, 32'h8765_4321, 32'd0);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		tick();
		tick();
		tick();
		stop_timer(32'd4);
		stop_timer(32'd4);
		stop_timer(32'd1);
		tick();
		// Fill the store, overflow it, then stop the timers in the middle and last slots.
		while (board.count < SLOTS)
			start_timer($urandom_range(0, 6), 1'($urandom_range(0, 1)));
		start_timer(32'd3, 1'b1);
		stop_timer(board.heap[SLOTS / 2].id);
		stop_timer(board.heap[SLOTS - 1].id);
		repeat (8)
			tick();
		// Drain all timers by stop so the random part starts empty.
		while (board.count > 0)
			stop_timer(board.heap[$urandom_range(0, board.count - 1)].id);

		// Random mix of starts, stops, ticks and unknown kinds, short intervals mostly.
		limit = 180;
		while (sent < limit) begin
			if (sent > limit - 30)
				calm = 1;
			case ($urandom_range(0, 9))
			0, 1, 2:
				start_timer($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8),
					$urandom_range(0, 3) == 0);
			3, 4:
				stop_timer(pick_id());
			9:
				send_item(KIND_UNUSED, $urandom, 1'b0, $urandom, $urandom, $urandom);
			default:
				tick();
			endcase
		end
		go_idle();
		calm = 1;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d items and %0d results, %0d of them expiries",
			sent, board.seen, board.expiries);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* heap_timer_scheduler.f */
hw/rtl/hts_pkg.sv
hw/rtl/heap_timer_scheduler.sv
hw/rtl/hts_checker.sv
tb/heap_timer_scheduler_tb.sv
